// ===== hw/rtl/rrps_pkg.sv =====
// Shared types, constants and glyph ramp for the radial ripple pixel shader.
// Used by rrps_front, rrps_back and radial_ripple_pixel_shader_top.
package rrps_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int MAX_DIM     = 1024;
  localparam int GLYPH_COUNT = 67;

  localparam int COORD_W = 10;
  localparam int DIM_W   = 11;
  localparam int POS_W   = 20;
  localparam int VEL_W   = 17;
  localparam int PH_W    = 16;
  localparam int STEP_W  = 16;
  localparam int GAIN_W  = 24;
  localparam int Q1_W    = 17;
  localparam int LIM_W   = DIM_W + FRAC_BITS;
  localparam int LVL_W   = 7;
  localparam int CHR_W   = 7;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // register indexes on the configuration port
  localparam logic [2:0] REG_FRAME_COLS  = 3'd0;
  localparam logic [2:0] REG_FRAME_ROWS  = 3'd1;
  localparam logic [2:0] REG_STEP_X      = 3'd2;
  localparam logic [2:0] REG_STEP_Y      = 3'd3;
  localparam logic [2:0] REG_PHASE_STEP  = 3'd4;
  localparam logic [2:0] REG_RADIAL_GAIN = 3'd5;
  localparam logic [2:0] REG_CONTRAST    = 3'd6;
  localparam logic [2:0] REG_BACKLIGHT   = 3'd7;

  // reset values
  localparam logic [DIM_W-1:0]  RST_FRAME_COLS  = 11'd80;
  localparam logic [DIM_W-1:0]  RST_FRAME_ROWS  = 11'd24;
  localparam logic [STEP_W-1:0] RST_STEP_X      = 16'd68;
  localparam logic [STEP_W-1:0] RST_STEP_Y      = 16'd61;
  localparam logic [PH_W-1:0]   RST_PHASE_STEP  = 16'd2782;
  localparam logic [GAIN_W-1:0] RST_RADIAL_GAIN = 24'd24887;
  localparam logic [Q1_W-1:0]   RST_CONTRAST    = 17'd13107;
  localparam logic [Q1_W-1:0]   RST_BACKLIGHT   = 17'd0;

  // sine polynomial coefficients, Q16
  localparam logic [16:0] SIN_A = 17'd102943;
  localparam logic [15:0] SIN_B = 16'd42047;
  localparam logic [12:0] SIN_C = 13'd4640;

  // ASCII codes of the 67-glyph ramp, darkest first
  localparam logic [CHR_W-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
    7'd32,  7'd46,  7'd39,  7'd96,  7'd94,  7'd34,  7'd44,  7'd58,  7'd59,  7'd73,
    7'd108, 7'd33,  7'd105, 7'd62,  7'd60,  7'd126, 7'd43,  7'd63,  7'd93,  7'd91,
    7'd125, 7'd123, 7'd49,  7'd41,  7'd40,  7'd124, 7'd92,  7'd47,  7'd116, 7'd102,
    7'd106, 7'd114, 7'd120, 7'd110, 7'd117, 7'd118, 7'd99,  7'd122, 7'd88,  7'd89,
    7'd85,  7'd74,  7'd67,  7'd76,  7'd81,  7'd48,  7'd79,  7'd90,  7'd109, 7'd119,
    7'd113, 7'd112, 7'd100, 7'd98,  7'd107, 7'd104, 7'd97,  7'd111, 7'd35,  7'd77,
    7'd87,  7'd38,  7'd56,  7'd37,  7'd66,  7'd64,  7'd36
  };

  // configuration as seen by front and back
  typedef struct packed {
    logic [DIM_W-1:0]  frame_cols;
    logic [DIM_W-1:0]  frame_rows;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
    logic              load_vx;
    logic              load_vy;
    logic [PH_W-1:0]   phase_step;
    logic [GAIN_W-1:0] radial_gain;
    logic [Q1_W-1:0]   contrast;
    logic [Q1_W-1:0]   backlight;
  } cfg_t;

  // one pixel request with the frame state it is shaded against
  typedef struct packed {
    logic [COORD_W-1:0]     row;
    logic [COORD_W-1:0]     col;
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic [PH_W-1:0]        ph;
  } item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos;
    logic signed [VEL_W-1:0] vel;
  } axis_t;

endpackage

// ===== hw/rtl/radial_ripple_pixel_shader_top.sv =====
// Top level of the radial ripple pixel shader: configuration registers,
// front end and shading back end. Depends on rrps_pkg, rrps_front, rrps_back.
//
// Usage:
// - Pixel requests enter on push/full with pixel_row, pixel_col, frame_start.
//   A request is taken when push is high and full is low. frame_start moves
//   the bouncing centre and lowers the phase before that pixel is shaded.
// - Results leave on empty/pop: shade_level and glyph_code show the oldest
//   result while empty is low; pop takes it.
// - Throughput is one pixel per clock while a full result queue does not hold the
//   pipeline. A request passes through the request queue, 32 pipeline stages (21
//   of them the square root, one bit each) and the result queue.
// - When pop is held low the result queue fills, the shading pipeline holds,
//   the four-entry request queue fills and full rises; nothing is lost.
// - Reset (rst, synchronous) empties both queues, centres at zero, phase zero,
//   velocities and registers at their defaults. Registers are to be written over
//   the APB-style port only while no request is outstanding; the block itself
//   does not enforce this. Writing step_x or step_y also reloads the matching velocity.
module radial_ripple_pixel_shader_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [rrps_pkg::COORD_W-1:0] pixel_row,
  input  logic [rrps_pkg::COORD_W-1:0] pixel_col,
  input  logic                         frame_start,
  output logic                         empty,
  input  logic                         pop,
  output logic [rrps_pkg::LVL_W-1:0]   shade_level,
  output logic [rrps_pkg::CHR_W-1:0]   glyph_code,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [rrps_pkg::DIM_W-1:0]  frame_cols, frame_rows;
  logic [rrps_pkg::STEP_W-1:0] step_x, step_y;
  logic [rrps_pkg::PH_W-1:0]   phase_step;
  logic [rrps_pkg::GAIN_W-1:0] radial_gain;
  logic [rrps_pkg::Q1_W-1:0]   contrast, backlight;

  logic            wr;
  logic [2:0]      ridx;
  rrps_pkg::cfg_t  cfg;
  logic            q_valid, q_pop;
  rrps_pkg::item_t q_item;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign ridx   = paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_cols  <= rrps_pkg::RST_FRAME_COLS;
      frame_rows  <= rrps_pkg::RST_FRAME_ROWS;
      step_x      <= rrps_pkg::RST_STEP_X;
      step_y      <= rrps_pkg::RST_STEP_Y;
      phase_step  <= rrps_pkg::RST_PHASE_STEP;
      radial_gain <= rrps_pkg::RST_RADIAL_GAIN;
      contrast    <= rrps_pkg::RST_CONTRAST;
      backlight   <= rrps_pkg::RST_BACKLIGHT;
    end else if (wr) begin
      unique case (ridx)
        rrps_pkg::REG_FRAME_COLS:  frame_cols  <= pwdata[rrps_pkg::DIM_W-1:0];
        rrps_pkg::REG_FRAME_ROWS:  frame_rows  <= pwdata[rrps_pkg::DIM_W-1:0];
        rrps_pkg::REG_STEP_X:      step_x      <= pwdata[rrps_pkg::STEP_W-1:0];
        rrps_pkg::REG_STEP_Y:      step_y      <= pwdata[rrps_pkg::STEP_W-1:0];
        rrps_pkg::REG_PHASE_STEP:  phase_step  <= pwdata[rrps_pkg::PH_W-1:0];
        rrps_pkg::REG_RADIAL_GAIN: radial_gain <= pwdata[rrps_pkg::GAIN_W-1:0];
        rrps_pkg::REG_CONTRAST:    contrast    <= pwdata[rrps_pkg::Q1_W-1:0];
        rrps_pkg::REG_BACKLIGHT:   backlight   <= pwdata[rrps_pkg::Q1_W-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (ridx)
      rrps_pkg::REG_FRAME_COLS:  prdata = 32'(frame_cols);
      rrps_pkg::REG_FRAME_ROWS:  prdata = 32'(frame_rows);
      rrps_pkg::REG_STEP_X:      prdata = 32'(step_x);
      rrps_pkg::REG_STEP_Y:      prdata = 32'(step_y);
      rrps_pkg::REG_PHASE_STEP:  prdata = 32'(phase_step);
      rrps_pkg::REG_RADIAL_GAIN: prdata = 32'(radial_gain);
      rrps_pkg::REG_CONTRAST:    prdata = 32'(contrast);
      rrps_pkg::REG_BACKLIGHT:   prdata = 32'(backlight);
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    cfg.frame_cols  = frame_cols;
    cfg.frame_rows  = frame_rows;
    cfg.step_x      = pwdata[rrps_pkg::STEP_W-1:0];
    cfg.step_y      = pwdata[rrps_pkg::STEP_W-1:0];
    cfg.load_vx     = wr && (ridx == rrps_pkg::REG_STEP_X);
    cfg.load_vy     = wr && (ridx == rrps_pkg::REG_STEP_Y);
    cfg.phase_step  = phase_step;
    cfg.radial_gain = radial_gain;
    cfg.contrast    = contrast;
    cfg.backlight   = backlight;
  end

  rrps_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .full        (full),
    .pixel_row   (pixel_row),
    .pixel_col   (pixel_col),
    .frame_start (frame_start),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop)
  );

  rrps_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .shade_level (shade_level),
    .glyph_code  (glyph_code)
  );

`ifndef SYNTHESIS
  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> (empty && !full))
    else $error("queues not empty after reset");

  // a shown result is always a real ramp level
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (shade_level <= 7'd66))
    else $error("shade level beyond ramp");

  // the back end never takes from an empty request queue
  a_front_drain: assert property (@(posedge clk) disable iff (rst)
    (q_pop && !q_valid) |-> 1'b0)
    else $error("back end took from an empty request queue");
`endif

endmodule

// ===== hw/rtl/rrps_front.sv =====
// Front end: accepts pixel requests, advances centre and phase on frame start,
// and queues each request with its frame state. Depends on rrps_pkg.
module rrps_front (
  input  logic                          clk,
  input  logic                          rst,
  input  rrps_pkg::cfg_t                cfg,
  input  logic                          push,
  output logic                          full,
  input  logic [rrps_pkg::COORD_W-1:0]  pixel_row,
  input  logic [rrps_pkg::COORD_W-1:0]  pixel_col,
  input  logic                          frame_start,
  output logic                          q_valid,
  output rrps_pkg::item_t               q_item,
  input  logic                          q_pop
);

  logic signed [rrps_pkg::POS_W-1:0] center_x, center_y;
  logic signed [rrps_pkg::VEL_W-1:0] velocity_x, velocity_y;
  logic [rrps_pkg::PH_W-1:0]         phase_turns;

  rrps_pkg::item_t                   qmem [rrps_pkg::Q_DEPTH];
  logic [rrps_pkg::Q_AW-1:0]         wptr, rptr;
  logic [rrps_pkg::Q_AW:0]           count;

  logic                              accept;
  rrps_pkg::axis_t                   ax_next, ay_next;
  logic [rrps_pkg::PH_W-1:0]         phase_next;
  rrps_pkg::item_t                   item_next;

  // clip a frame dimension and scale it to a bounce limit
  function automatic logic [rrps_pkg::LIM_W-1:0] dim_limit(
    input logic [rrps_pkg::DIM_W-1:0] dim
  );
    logic [rrps_pkg::DIM_W-1:0] d;
    d = (dim > rrps_pkg::DIM_W'(rrps_pkg::MAX_DIM)) ?
        rrps_pkg::DIM_W'(rrps_pkg::MAX_DIM) : dim;
    return {d, {rrps_pkg::FRAC_BITS{1'b0}}};
  endfunction

  // one axis move with bounce and saturation
  function automatic rrps_pkg::axis_t axis_step(
    input logic signed [rrps_pkg::POS_W-1:0] pos,
    input logic signed [rrps_pkg::VEL_W-1:0] vel,
    input logic [rrps_pkg::LIM_W-1:0]        lim
  );
    logic signed [rrps_pkg::POS_W:0] p;
    logic signed [rrps_pkg::POS_W:0] limx;
    logic signed [rrps_pkg::POS_W:0] velx;
    rrps_pkg::axis_t                 r;
    velx  = {{(rrps_pkg::POS_W+1-rrps_pkg::VEL_W){vel[rrps_pkg::VEL_W-1]}}, vel};
    limx  = {{(rrps_pkg::POS_W+1-rrps_pkg::LIM_W){1'b0}}, lim};
    p     = {pos[rrps_pkg::POS_W-1], pos} + velx;
    r.vel = vel;
    if (p < 0) begin
      p     = '0;
      r.vel = -vel;
    end else if (p >= limx) begin
      p     = limx - velx;
      r.vel = -vel;
    end
    if (p > $signed({2'b00, {(rrps_pkg::POS_W-1){1'b1}}})) begin
      p = {2'b00, {(rrps_pkg::POS_W-1){1'b1}}};
    end else if (p < $signed({2'b11, {(rrps_pkg::POS_W-1){1'b0}}})) begin
      p = {2'b11, {(rrps_pkg::POS_W-1){1'b0}}};
    end
    r.pos = p[rrps_pkg::POS_W-1:0];
    return r;
  endfunction

  // frame advance and request capture
  always_comb begin
    accept     = push && !full;
    phase_next = phase_turns - cfg.phase_step;
    ax_next    = axis_step(center_x, velocity_x, dim_limit(cfg.frame_cols));
    ay_next    = axis_step(center_y, velocity_y, dim_limit(cfg.frame_rows));
    item_next.row = pixel_row;
    item_next.col = pixel_col;
    if (frame_start) begin
      item_next.cx = ax_next.pos;
      item_next.cy = ay_next.pos;
      item_next.ph = phase_next;
    end else begin
      item_next.cx = center_x;
      item_next.cy = center_y;
      item_next.ph = phase_turns;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      velocity_x  <= {1'b0, rrps_pkg::RST_STEP_X};
      velocity_y  <= {1'b0, rrps_pkg::RST_STEP_Y};
      phase_turns <= '0;
    end else begin
      if (accept && frame_start) begin
        center_x    <= ax_next.pos;
        center_y    <= ay_next.pos;
        velocity_x  <= ax_next.vel;
        velocity_y  <= ay_next.vel;
        phase_turns <= phase_next;
      end
      if (cfg.load_vx) velocity_x <= {1'b0, cfg.step_x};
      if (cfg.load_vy) velocity_y <= {1'b0, cfg.step_y};
    end
  end

  // request queue to the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (accept) wptr <= wptr + 1'b1;
      if (q_pop && q_valid) rptr <= rptr + 1'b1;
      count <= count + {{rrps_pkg::Q_AW{1'b0}}, accept}
                     - {{rrps_pkg::Q_AW{1'b0}}, q_pop && q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) qmem[wptr] <= item_next;
  end

  assign full    = (count == (rrps_pkg::Q_AW+1)'(rrps_pkg::Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = qmem[rptr];

endmodule

// ===== hw/rtl/rrps_back.sv =====
// Back end: shading pipeline (distance, square root, wave angle, cosine,
// contrast, glyph) and the result queue. Depends on rrps_pkg.
module rrps_back (
  input  logic                        clk,
  input  logic                        rst,
  input  rrps_pkg::cfg_t              cfg,
  input  logic                        q_valid,
  input  rrps_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        empty,
  input  logic                        pop,
  output logic [rrps_pkg::LVL_W-1:0]  shade_level,
  output logic [rrps_pkg::CHR_W-1:0]  glyph_code
);

  localparam int AB_W   = rrps_pkg::POS_W;
  localparam int RAD_W  = 2 * AB_W + 2;
  localparam int SQ_W   = RAD_W + 1;
  localparam int SQ_N   = RAD_W / 2;
  localparam int D_W    = SQ_N;
  localparam int PRE_N  = 3;
  localparam int POST_N = 8;
  localparam int NST    = PRE_N + SQ_N + POST_N;
  localparam int PH_W   = rrps_pkg::PH_W;
  localparam int SH     = rrps_pkg::FRAC_BITS + 1;

  logic [NST-1:0] vld;
  logic           en;
  logic           opush;

  // P0: absolute offsets
  logic [AB_W-1:0] p0_a, p0_b;
  logic [PH_W-1:0] p0_ph;
  logic signed [AB_W+1:0] da, db;
  // P1: squares
  logic [2*AB_W-1:0] p1_a2, p1_b2;
  logic [PH_W-1:0]   p1_ph;
  // square root stages; index 0 holds the radicand
  logic [SQ_W-1:0] sq_rem [SQ_N+1];
  logic [SQ_W-1:0] sq_res [SQ_N+1];
  logic [PH_W-1:0] sq_ph  [SQ_N+1];
  logic [SQ_W-1:0] rem_next [SQ_N+1];
  logic [SQ_W-1:0] res_next [SQ_N+1];
  // angle and cosine
  logic [PH_W-1:0]   p3_ang, p3_ph;
  logic [14:0]       p4_mag;
  logic              p4_neg;
  logic [14:0]       p5_z2, p5_mag;
  logic              p5_neg;
  logic [15:0]       p6_inner;
  logic [14:0]       p6_z2, p6_mag;
  logic              p6_neg;
  logic [16:0]       p7_poly;
  logic [14:0]       p7_mag;
  logic              p7_neg;
  logic signed [18:0] p8_cos;
  logic [rrps_pkg::Q1_W-1:0]  p9_v;
  logic [rrps_pkg::LVL_W-1:0] p10_lvl;
  logic [rrps_pkg::CHR_W-1:0] p10_chr;

  logic [rrps_pkg::GAIN_W+D_W-1:0] gprod;
  logic [PH_W-1:0]   theta, u4;
  logic signed [16:0] s4;
  logic [29:0]       mm5;
  logic [27:0]       zc6;
  logic [30:0]       zi7;
  logic [31:0]       mp8;
  logic [17:0]       r8;
  logic signed [18:0] c9;
  logic [16:0]       s9;
  logic [33:0]       m9;
  logic [18:0]       v9;
  logic [23:0]       l10;

  // whole pipeline holds only when the last stage cannot enter the result queue
  logic [1:0] ocnt;
  assign en    = !(vld[NST-1] && ocnt == 2'd2 && !pop);
  assign q_pop = en && q_valid;
  assign opush = vld[NST-1] && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], q_pop};
    end
  end

  // offsets, squares, radicand
  always_comb begin
    da = $signed({2'b00, q_item.row, {rrps_pkg::FRAC_BITS{1'b0}}})
       - $signed({{2{q_item.cy[AB_W-1]}}, q_item.cy});
    db = $signed({2'b00, q_item.col, {rrps_pkg::FRAC_BITS{1'b0}}})
       - $signed({{2{q_item.cx[AB_W-1]}}, q_item.cx});
    if (da < 0) da = -da;
    if (db < 0) db = -db;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_a  <= da[AB_W-1:0];
      p0_b  <= db[AB_W-1:0];
      p0_ph <= q_item.ph;
      p1_a2 <= p0_a * p0_a;
      p1_b2 <= p0_b * p0_b;
      p1_ph <= p0_ph;
      sq_rem[0] <= {1'b0, {p1_a2, 2'b00} + {2'b00, p1_b2}};
      sq_res[0] <= '0;
      sq_ph[0]  <= p1_ph;
    end
  end

  // digit-by-digit square root, one result bit per stage
  always_comb begin
    rem_next[0] = '0;
    res_next[0] = '0;
    for (int i = 1; i <= SQ_N; i++) begin
      if (sq_rem[i-1] >= sq_res[i-1] + (SQ_W'(1) << (2 * (SQ_N - i)))) begin
        rem_next[i] = sq_rem[i-1] - sq_res[i-1] - (SQ_W'(1) << (2 * (SQ_N - i)));
        res_next[i] = (sq_res[i-1] >> 1) + (SQ_W'(1) << (2 * (SQ_N - i)));
      end else begin
        rem_next[i] = sq_rem[i-1];
        res_next[i] = sq_res[i-1] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 1; i <= SQ_N; i++) begin
        sq_rem[i] <= rem_next[i];
        sq_res[i] <= res_next[i];
        sq_ph[i]  <= sq_ph[i-1];
      end
    end
  end

  // wave angle and cosine fold
  always_comb begin
    gprod = cfg.radial_gain * sq_res[SQ_N][D_W-1:0];
    theta = p3_ang + p3_ph;
    u4    = theta + 16'd16384;
    s4    = $signed({u4[15], u4});
    if (s4 > 17'sd16384) begin
      s4 = 17'sd32768 - s4;
    end else if (s4 < -17'sd16384) begin
      s4 = -17'sd32768 - s4;
    end
    mm5 = p4_mag * p4_mag;
    zc6 = p5_z2 * rrps_pkg::SIN_C;
    zi7 = p6_z2 * p6_inner;
    mp8 = p7_mag * p7_poly;
    r8  = mp8[31:14];
    c9  = p8_cos + 19'sd65536;
    s9  = c9[17:1];
    m9  = s9 * cfg.contrast;
    v9  = {1'b0, m9[33:16]} + {2'b00, cfg.backlight};
    l10 = 7'(rrps_pkg::GLYPH_COUNT - 1) * p9_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_ang   <= gprod[SH+PH_W-1:SH];
      p3_ph    <= sq_ph[SQ_N];
      p4_neg   <= s4 < 0;
      p4_mag   <= (s4 < 0) ? 15'(-s4) : 15'(s4);
      p5_z2    <= mm5[28:14];
      p5_mag   <= p4_mag;
      p5_neg   <= p4_neg;
      p6_inner <= rrps_pkg::SIN_B - {2'b00, zc6[27:14]};
      p6_z2    <= p5_z2;
      p6_mag   <= p5_mag;
      p6_neg   <= p5_neg;
      p7_poly  <= rrps_pkg::SIN_A - zi7[30:14];
      p7_mag   <= p6_mag;
      p7_neg   <= p6_neg;
      p8_cos   <= p7_neg ? -$signed({1'b0, r8}) : $signed({1'b0, r8});
      p9_v     <= (v9 > 19'd65536) ? 17'd65536 : v9[16:0];
      p10_lvl  <= l10[22:16];
      p10_chr  <= rrps_pkg::GLYPH_ROM[l10[22:16]];
    end
  end

  // result queue, two entries
  logic [rrps_pkg::LVL_W-1:0] olvl [2];
  logic [rrps_pkg::CHR_W-1:0] ochr [2];
  logic owp, orp;
  logic opop;

  assign empty = (ocnt == 2'd0);
  assign opop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= '0;
      owp  <= 1'b0;
      orp  <= 1'b0;
    end else begin
      if (opush) owp <= !owp;
      if (opop)  orp <= !orp;
      ocnt <= ocnt + {1'b0, opush} - {1'b0, opop};
    end
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      olvl[owp] <= p10_lvl;
      ochr[owp] <= p10_chr;
    end
  end

  assign shade_level = olvl[orp];
  assign glyph_code  = ochr[orp];

endmodule
